// ----- hw/rtl/acmg_pkg.sv -----
// shared widths, register indexes, mix coefficients and helpers for the channel mixer
package acmg_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int LANES       = 6;
    localparam int GAIN_W      = 20;
    localparam int GAIN_FRAC   = 12;
    localparam int COEF_W      = 17;
    localparam int COEF_FRAC   = 16;
    localparam int MODE_W      = 2;
    localparam int COUNT_W     = 3;
    localparam int INDEX_W     = 2;
    localparam int CFG_W       = GAIN_W;

    localparam int PROD_W   = SAMPLE_BITS + GAIN_W + 1;
    localparam int SUM_W    = SAMPLE_BITS + COEF_W + 2;
    localparam int FULL_W   = SUM_W + GAIN_W + 1;
    localparam int MIX_FRAC = COEF_FRAC + GAIN_FRAC;

    localparam int GAIN_ROUND = 2 ** GAIN_FRAC - 1;
    localparam int MIX_ROUND  = 2 ** MIX_FRAC - 1;

    localparam logic [INDEX_W-1:0] REG_MIX_MODE      = INDEX_W'(0);
    localparam logic [INDEX_W-1:0] REG_CHANNEL_COUNT = INDEX_W'(1);
    localparam logic [INDEX_W-1:0] REG_VOLUME_GAIN   = INDEX_W'(2);

    localparam logic [MODE_W-1:0] MODE_DOWNMIX = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_UPMIX   = MODE_W'(2);

    localparam logic [MODE_W-1:0]  MIX_MODE_RESET      = MODE_W'(0);
    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RESET = COUNT_W'(2);
    localparam logic [GAIN_W-1:0]  VOLUME_GAIN_RESET   = GAIN_W'(4096);

    // unsigned q1.16: front, front, centre, lfe, back, back
    localparam logic [GAIN_W-1:0] COEF [LANES] = '{
        GAIN_W'(65536), GAIN_W'(65536), GAIN_W'(39059),
        GAIN_W'(23200), GAIN_W'(46334), GAIN_W'(46334)
    };

    typedef struct packed {
        logic             valid;
        logic             down;
        logic [LANES-1:0] en;
    } ctl_t;

    function automatic logic signed [SAMPLE_BITS-1:0] saturate(
        input logic signed [FULL_W-1:0] v
    );
        logic signed [FULL_W-1:0]      hi;
        logic signed [FULL_W-1:0]      lo;
        logic signed [SAMPLE_BITS-1:0] r;
        hi = {{(FULL_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
        lo = ~hi;
        if (v > hi)
        begin
            r = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end
        else if (v < lo)
        begin
            r = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        end
        else
        begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/acmg_lane.sv -----
// one mixer lane: sample times coefficient or gain, then q8.12 truncation and saturation
module acmg_lane (
    input  logic                                       clk,
    input  logic signed [acmg_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic        [acmg_pkg::GAIN_W-1:0]         multiplier,
    output logic signed [acmg_pkg::PROD_W-1:0]         product,
    output logic signed [acmg_pkg::SAMPLE_BITS-1:0]    scaled
);

    logic signed [acmg_pkg::PROD_W-1:0]      product_reg;
    logic signed [acmg_pkg::PROD_W-1:0]      product_next;
    logic signed [acmg_pkg::PROD_W-1:0]      rounded;
    logic signed [acmg_pkg::PROD_W-1:0]      shifted;
    logic signed [acmg_pkg::SAMPLE_BITS-1:0] scaled_reg;
    logic signed [acmg_pkg::SAMPLE_BITS-1:0] scaled_next;
    logic signed [acmg_pkg::SAMPLE_BITS-1:0] scaled_d_reg;

    always_comb
    begin
        product_next = sample * signed'({1'b0, multiplier});
    end

    // truncate toward zero
    always_comb
    begin
        rounded = product_reg[acmg_pkg::PROD_W-1]
                ? product_reg + acmg_pkg::PROD_W'(acmg_pkg::GAIN_ROUND)
                : product_reg;
        shifted = rounded >>> acmg_pkg::GAIN_FRAC;
        scaled_next = acmg_pkg::saturate(acmg_pkg::FULL_W'(shifted));
    end

    always_ff @(posedge clk)
    begin
        product_reg  <= product_next;
        scaled_reg   <= scaled_next;
        scaled_d_reg <= scaled_reg;
    end

    assign product = product_reg;
    assign scaled  = scaled_d_reg;

endmodule

// ----- hw/rtl/acmg_merge.sv -----
// downmix merge: sums lane products per side, applies gain, truncates and saturates
module acmg_merge (
    input  logic                                       clk,
    input  logic        [acmg_pkg::GAIN_W-1:0]         gain,
    input  logic signed [acmg_pkg::PROD_W-1:0]         products [acmg_pkg::LANES],
    output logic signed [acmg_pkg::SAMPLE_BITS-1:0]    left,
    output logic signed [acmg_pkg::SAMPLE_BITS-1:0]    right
);

    logic signed [acmg_pkg::SUM_W-1:0]  part [acmg_pkg::LANES];
    logic signed [acmg_pkg::SUM_W-1:0]  common;
    logic signed [acmg_pkg::SUM_W-1:0]  left_sum_reg;
    logic signed [acmg_pkg::SUM_W-1:0]  left_sum_next;
    logic signed [acmg_pkg::SUM_W-1:0]  right_sum_reg;
    logic signed [acmg_pkg::SUM_W-1:0]  right_sum_next;
    logic signed [acmg_pkg::FULL_W-1:0] left_prod_reg;
    logic signed [acmg_pkg::FULL_W-1:0] left_prod_next;
    logic signed [acmg_pkg::FULL_W-1:0] right_prod_reg;
    logic signed [acmg_pkg::FULL_W-1:0] right_prod_next;
    logic signed [acmg_pkg::FULL_W-1:0] left_rnd;
    logic signed [acmg_pkg::FULL_W-1:0] right_rnd;

    always_comb
    begin
        for (int i = 0; i < acmg_pkg::LANES; i++)
        begin
            part[i] = signed'(products[i][acmg_pkg::SUM_W-1:0]);
        end
        common         = part[2] + part[3];
        left_sum_next  = part[0] + common + part[4];
        right_sum_next = part[1] + common + part[5];
    end

    always_comb
    begin
        left_prod_next  = left_sum_reg * signed'({1'b0, gain});
        right_prod_next = right_sum_reg * signed'({1'b0, gain});
    end

    // truncate toward zero
    always_comb
    begin
        left_rnd  = left_prod_reg[acmg_pkg::FULL_W-1]
                  ? left_prod_reg + acmg_pkg::FULL_W'(acmg_pkg::MIX_ROUND)
                  : left_prod_reg;
        right_rnd = right_prod_reg[acmg_pkg::FULL_W-1]
                  ? right_prod_reg + acmg_pkg::FULL_W'(acmg_pkg::MIX_ROUND)
                  : right_prod_reg;
        left  = acmg_pkg::saturate(left_rnd >>> acmg_pkg::MIX_FRAC);
        right = acmg_pkg::saturate(right_rnd >>> acmg_pkg::MIX_FRAC);
    end

    always_ff @(posedge clk)
    begin
        left_sum_reg   <= left_sum_next;
        right_sum_reg  <= right_sum_next;
        left_prod_reg  <= left_prod_next;
        right_prod_reg <= right_prod_next;
    end

endmodule

// ----- hw/rtl/audio_channel_mix_gain_top.sv -----
// top level of the channel mixer: configuration registers, six lanes, merge and output stage
//
// Usage:
//   A frame of six signed samples is requested by raising start; with busy low
//   (it is never raised) the frame is taken at that clock edge, so one frame
//   may be requested every cycle.
//   After a request passes ctl1_reg, ctl2_reg, ctl3_reg and done_reg, done is high
//   for exactly one cycle and out_lane0 to out_lane5 hold the mixed frame.
//   Results appear in request order; the receiver cannot stall and must take
//   each frame when done is high. The datapath has four register stages: lane
//   multiply, side sum or lane truncation, gain multiply of the downmix, output register.
//   Configuration goes through cfg_write, cfg_index and cfg_data, one register
//   per cycle. The user must write only while no frame is in flight; it is not enforced.
//   Reset clears the control pipeline (not the data) and loads mode scaling,
//   two channels and unity gain; no frame is produced until a request follows reset.
module audio_channel_mix_gain_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    cfg_write,
    input  logic        [acmg_pkg::INDEX_W-1:0]     cfg_index,
    input  logic        [acmg_pkg::CFG_W-1:0]       cfg_data,
    input  logic signed [acmg_pkg::SAMPLE_BITS-1:0] in_front_left,
    input  logic signed [acmg_pkg::SAMPLE_BITS-1:0] in_front_right,
    input  logic signed [acmg_pkg::SAMPLE_BITS-1:0] in_center,
    input  logic signed [acmg_pkg::SAMPLE_BITS-1:0] in_low_freq,
    input  logic signed [acmg_pkg::SAMPLE_BITS-1:0] in_back_left,
    input  logic signed [acmg_pkg::SAMPLE_BITS-1:0] in_back_right,
    output logic                                    done,
    output logic signed [acmg_pkg::SAMPLE_BITS-1:0] out_lane0,
    output logic signed [acmg_pkg::SAMPLE_BITS-1:0] out_lane1,
    output logic signed [acmg_pkg::SAMPLE_BITS-1:0] out_lane2,
    output logic signed [acmg_pkg::SAMPLE_BITS-1:0] out_lane3,
    output logic signed [acmg_pkg::SAMPLE_BITS-1:0] out_lane4,
    output logic signed [acmg_pkg::SAMPLE_BITS-1:0] out_lane5
);

    logic [acmg_pkg::MODE_W-1:0]  mix_mode_reg;
    logic [acmg_pkg::COUNT_W-1:0] channel_count_reg;
    logic [acmg_pkg::GAIN_W-1:0]  volume_gain_reg;

    acmg_pkg::ctl_t ctl_next;
    acmg_pkg::ctl_t ctl1_reg;
    acmg_pkg::ctl_t ctl2_reg;
    acmg_pkg::ctl_t ctl3_reg;
    logic           done_reg;

    logic signed [acmg_pkg::SAMPLE_BITS-1:0] samples    [acmg_pkg::LANES];
    logic        [acmg_pkg::GAIN_W-1:0]      mult       [acmg_pkg::LANES];
    logic signed [acmg_pkg::PROD_W-1:0]      products   [acmg_pkg::LANES];
    logic signed [acmg_pkg::SAMPLE_BITS-1:0] scaled     [acmg_pkg::LANES];
    logic signed [acmg_pkg::SAMPLE_BITS-1:0] out_next   [acmg_pkg::LANES];
    logic signed [acmg_pkg::SAMPLE_BITS-1:0] out_reg    [acmg_pkg::LANES];
    logic signed [acmg_pkg::SAMPLE_BITS-1:0] mix_left;
    logic signed [acmg_pkg::SAMPLE_BITS-1:0] mix_right;

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_mode_reg      <= acmg_pkg::MIX_MODE_RESET;
            channel_count_reg <= acmg_pkg::CHANNEL_COUNT_RESET;
            volume_gain_reg   <= acmg_pkg::VOLUME_GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                acmg_pkg::REG_MIX_MODE:
                begin
                    mix_mode_reg <= cfg_data[acmg_pkg::MODE_W-1:0];
                end
                acmg_pkg::REG_CHANNEL_COUNT:
                begin
                    channel_count_reg <= cfg_data[acmg_pkg::COUNT_W-1:0];
                end
                acmg_pkg::REG_VOLUME_GAIN:
                begin
                    volume_gain_reg <= cfg_data[acmg_pkg::GAIN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign samples[0] = in_front_left;
    assign samples[1] = in_front_right;
    assign samples[2] = in_center;
    assign samples[3] = in_low_freq;
    assign samples[4] = in_back_left;
    assign samples[5] = in_back_right;

    // request control, lane enables and lane multipliers
    always_comb
    begin
        ctl_next.valid = start && !busy;
        ctl_next.down  = (mix_mode_reg == acmg_pkg::MODE_DOWNMIX);
        for (int i = 0; i < acmg_pkg::LANES; i++)
        begin
            if (mix_mode_reg == acmg_pkg::MODE_UPMIX)
            begin
                ctl_next.en[i] = (i < 2);
            end
            else
            begin
                ctl_next.en[i] = (channel_count_reg > acmg_pkg::COUNT_W'(i));
            end
            mult[i] = ctl_next.down ? acmg_pkg::COEF[i] : volume_gain_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= ctl_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            done_reg <= ctl3_reg.valid;
        end
    end

    for (genvar g = 0; g < acmg_pkg::LANES; g++)
    begin : g_lane
        acmg_lane u_lane (
            .clk        (clk),
            .sample     (samples[g]),
            .multiplier (mult[g]),
            .product    (products[g]),
            .scaled     (scaled[g])
        );
    end

    acmg_merge u_merge (
        .clk      (clk),
        .gain     (volume_gain_reg),
        .products (products),
        .left     (mix_left),
        .right    (mix_right)
    );

    // output selection
    always_comb
    begin
        for (int i = 0; i < acmg_pkg::LANES; i++)
        begin
            if (ctl3_reg.down)
            begin
                if (i == 0)
                begin
                    out_next[i] = mix_left;
                end
                else if (i == 1)
                begin
                    out_next[i] = mix_right;
                end
                else
                begin
                    out_next[i] = '0;
                end
            end
            else
            begin
                out_next[i] = ctl3_reg.en[i] ? scaled[i] : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < acmg_pkg::LANES; i++)
        begin
            out_reg[i] <= out_next[i];
        end
    end

    assign done      = done_reg;
    assign out_lane0 = out_reg[0];
    assign out_lane1 = out_reg[1];
    assign out_lane2 = out_reg[2];
    assign out_lane3 = out_reg[3];
    assign out_lane4 = out_reg[4];
    assign out_lane5 = out_reg[5];

endmodule

// ----- sim/audio_channel_mix_gain_top_tb.sv -----
// self-checking testbench for the channel mixer: queued driver, strobe monitor, frame predictor
module audio_channel_mix_gain_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import acmg_pkg::*;

    typedef logic [LANES-1:0][SAMPLE_BITS-1:0] frame_t;

    typedef struct {
        logic               is_cfg;
        logic [INDEX_W-1:0] idx;
        logic [CFG_W-1:0]   data;
        frame_t             smp;
    } mix_req_t;

    localparam logic [MODE_W-1:0] MODE_SCALE     = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_SCALE_ALT = MODE_W'(3);

    localparam longint MIX_K_FRONT  = 65536;
    localparam longint MIX_K_CENTRE = 39059;
    localparam longint MIX_K_LFE    = 23200;
    localparam longint MIX_K_BACK   = 46334;
    localparam longint GAIN_ONE     = 64'sd1 <<< GAIN_FRAC;
    localparam longint MIX_ONE      = 64'sd1 <<< MIX_FRAC;
    localparam logic [SAMPLE_BITS-1:0] S_MAX = 16'h7FFF;
    localparam logic [SAMPLE_BITS-1:0] S_MIN = 16'h8000;
    localparam int RANDOM_FRAMES = 1050;

    logic               clk;
    logic               rst_n;
    logic               start       = 1'b0;
    logic               cfg_write   = 1'b0;
    logic [INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]   cfg_data    = '0;
    frame_t             drive_frame = '0;
    logic               busy;
    logic               done;
    logic signed [SAMPLE_BITS-1:0] out_lane0;
    logic signed [SAMPLE_BITS-1:0] out_lane1;
    logic signed [SAMPLE_BITS-1:0] out_lane2;
    logic signed [SAMPLE_BITS-1:0] out_lane3;
    logic signed [SAMPLE_BITS-1:0] out_lane4;
    logic signed [SAMPLE_BITS-1:0] out_lane5;

    mix_req_t           pend_q[$];
    frame_t             mixed_frames_q[$];
    logic [MODE_W-1:0]  cur_mode;
    logic [COUNT_W-1:0] cur_count;
    logic [GAIN_W-1:0]  cur_gain;
    int                 idle_left;
    int                 burst_left;
    int                 err_count = 0;

    audio_channel_mix_gain_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_front_left  (drive_frame[0]),
        .in_front_right (drive_frame[1]),
        .in_center      (drive_frame[2]),
        .in_low_freq    (drive_frame[3]),
        .in_back_left   (drive_frame[4]),
        .in_back_right  (drive_frame[5]),
        .done           (done),
        .out_lane0      (out_lane0),
        .out_lane1      (out_lane1),
        .out_lane2      (out_lane2),
        .out_lane3      (out_lane3),
        .out_lane4      (out_lane4),
        .out_lane5      (out_lane5)
    );

    function automatic logic [SAMPLE_BITS-1:0] clamp_sample(longint v);
        if (v > 32767)
        begin
            return S_MAX;
        end
        if (v < -32768)
        begin
            return S_MIN;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic frame_t mix_frame(frame_t f, logic [MODE_W-1:0] mode,
                                         logic [COUNT_W-1:0] count, logic [GAIN_W-1:0] gain);
        frame_t r;
        longint s[LANES];
        longint g;
        longint common;
        longint left;
        longint right;
        int     n;
        r = '0;
        g = longint'(gain);
        for (int i = 0; i < LANES; i++)
        begin
            s[i] = longint'($signed(f[i]));
        end
        if (mode == MODE_DOWNMIX)
        begin
            common = s[2] * MIX_K_CENTRE + s[3] * MIX_K_LFE;
            left   = s[0] * MIX_K_FRONT + common + s[4] * MIX_K_BACK;
            right  = s[1] * MIX_K_FRONT + common + s[5] * MIX_K_BACK;
            r[0]   = clamp_sample((left * g) / MIX_ONE);
            r[1]   = clamp_sample((right * g) / MIX_ONE);
        end
        else if (mode == MODE_UPMIX)
        begin
            r[0] = clamp_sample((s[0] * g) / GAIN_ONE);
            r[1] = clamp_sample((s[1] * g) / GAIN_ONE);
        end
        else
        begin
            n = (count > LANES) ? LANES : int'(count);
            for (int i = 0; i < n; i++)
            begin
                r[i] = clamp_sample((s[i] * g) / GAIN_ONE);
            end
        end
        return r;
    endfunction

    function automatic frame_t fill_frame(logic [SAMPLE_BITS-1:0] v);
        return {LANES{v}};
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SAMPLE_BITS'($urandom_range(0, 64) - 32);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic frame_t pick_frame();
        frame_t f;
        for (int i = 0; i < LANES; i++)
        begin
            f[i] = pick_sample();
        end
        return f;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'(1);
            3:       return VOLUME_GAIN_RESET;
            4:       return GAIN_W'($urandom_range(0, 8191));
            5:       return GAIN_W'($urandom_range(0, 255));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    task automatic push_frame(frame_t f);
        mix_req_t r;
        r.is_cfg = 1'b0;
        r.idx    = '0;
        r.data   = '0;
        r.smp    = f;
        pend_q.push_back(r);
    endtask

    task automatic push_cfg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
        mix_req_t r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        r.smp    = '0;
        pend_q.push_back(r);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic     n_start;
        logic     n_cfg;
        mix_req_t head;
        if (!rst_n)
        begin
            start       <= 1'b0;
            cfg_write   <= 1'b0;
            cfg_index   <= '0;
            cfg_data    <= '0;
            drive_frame <= '0;
            cur_mode    = MIX_MODE_RESET;
            cur_count   = CHANNEL_COUNT_RESET;
            cur_gain    = VOLUME_GAIN_RESET;
            idle_left   = 0;
            burst_left  = 0;
        end
        else
        begin
            n_start = start && busy;
            n_cfg   = 1'b0;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MIX_MODE:      cur_mode  = cfg_data[MODE_W-1:0];
                    REG_CHANNEL_COUNT: cur_count = cfg_data[COUNT_W-1:0];
                    REG_VOLUME_GAIN:   cur_gain  = cfg_data[GAIN_W-1:0];
                    default:           ;
                endcase
            end
            if (start && !busy)
            begin
                mixed_frames_q.push_back(mix_frame(drive_frame, cur_mode, cur_count, cur_gain));
                if (burst_left > 0)
                begin
                    burst_left--;
                    idle_left = 0;
                end
                else
                begin
                    idle_left = $urandom_range(0, 7);
                    if ($urandom_range(0, 15) == 0)
                    begin
                        burst_left = $urandom_range(10, 50);
                    end
                end
            end
            if (!n_start)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                end
                else if (pend_q.size() != 0)
                begin
                    head = pend_q[0];
                    if (!head.is_cfg)
                    begin
                        n_start = 1'b1;
                        drive_frame <= head.smp;
                        void'(pend_q.pop_front());
                    end
                    else if (mixed_frames_q.size() == 0)
                    begin
                        n_cfg = 1'b1;
                        cfg_index <= head.idx;
                        cfg_data  <= head.data;
                        void'(pend_q.pop_front());
                    end
                end
            end
            start     <= n_start;
            cfg_write <= n_cfg;
        end
    end

    always @(posedge clk)
    begin : check_proc
        frame_t got;
        frame_t want;
        if (rst_n && done)
        begin
            got = {out_lane5, out_lane4, out_lane3, out_lane2, out_lane1, out_lane0};
            if (mixed_frames_q.size() == 0)
            begin
                $error("done with no request outstanding");
                err_count++;
            end
            else
            begin
                want = mixed_frames_q.pop_front();
                for (int i = 0; i < LANES; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        $error("out_lane%0d expected %0d actual %0d",
                               i, $signed(want[i]), $signed(got[i]));
                        err_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int sent;
        int n;
        rst_n = 1'b0;

        push_frame(fill_frame(S_MAX));
        push_frame(fill_frame(S_MIN));
        push_frame(fill_frame('0));
        push_frame({S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX});

        push_cfg(REG_MIX_MODE, CFG_W'(MODE_DOWNMIX));
        push_frame(fill_frame(S_MAX));
        push_frame(fill_frame(S_MIN));
        push_frame({16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001});
        push_frame(pick_frame());

        push_cfg(REG_VOLUME_GAIN, '1);
        push_frame(fill_frame(S_MAX));
        push_frame(fill_frame(16'h0001));

        // upmix ignores the four extra input lanes
        push_cfg(REG_MIX_MODE, CFG_W'(MODE_UPMIX));
        push_frame(fill_frame(S_MAX));
        push_frame(fill_frame(S_MIN));
        push_frame(pick_frame());

        push_cfg(REG_MIX_MODE, CFG_W'(MODE_SCALE_ALT));
        push_cfg(REG_CHANNEL_COUNT, CFG_W'(6));
        push_cfg(REG_VOLUME_GAIN, '0);
        push_frame(fill_frame(S_MAX));
        push_cfg(REG_VOLUME_GAIN, CFG_W'(VOLUME_GAIN_RESET));
        push_frame(pick_frame());

        push_cfg(REG_MIX_MODE, CFG_W'(MODE_SCALE));
        push_cfg(REG_CHANNEL_COUNT, CFG_W'(0));
        push_frame(fill_frame(S_MAX));

        push_cfg(REG_CHANNEL_COUNT, CFG_W'(7));
        push_cfg(REG_VOLUME_GAIN, CFG_W'(1));
        push_frame(fill_frame(S_MIN));
        push_frame(fill_frame(16'hFFFF));

        push_cfg(REG_CHANNEL_COUNT, CFG_W'(1));
        push_cfg(REG_VOLUME_GAIN, CFG_W'(4095));
        push_frame(pick_frame());

        sent = 0;
        while (sent < RANDOM_FRAMES)
        begin
            push_cfg(REG_MIX_MODE, CFG_W'($urandom_range(0, 3)));
            push_cfg(REG_CHANNEL_COUNT, CFG_W'($urandom_range(0, 7)));
            push_cfg(REG_VOLUME_GAIN, CFG_W'(pick_gain()));
            n = $urandom_range(10, 60);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    push_frame(fill_frame(($urandom_range(0, 1) == 0) ? S_MAX : S_MIN));
                end
                else
                begin
                    push_frame(pick_frame());
                end
            end
            sent += n;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || start || mixed_frames_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (err_count == 0)
        begin
            $display("audio_channel_mix_gain_top test passed");
        end
        else
        begin
            $display("audio_channel_mix_gain_top test failed");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("audio_channel_mix_gain_top test failed");
        $finish;
    end

endmodule
